### rtl/ffpd_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed frame payload deframer: frame geometry, header
// offsets, result kind codes and the job record passed from front to back.
package ffpd_pkg;

   localparam int FRAME_BYTES  = 1024;
   localparam int HEADER_BYTES = 100;
   localparam int OFS_W        = $clog2(FRAME_BYTES);

   localparam int OFS_TYPE       = 2;
   localparam int OFS_SEQ        = 6;
   localparam int OFS_VALID      = 10;
   localparam int OFS_TOTAL      = 14;
   localparam int OFS_HEADER_END = 18;

   localparam logic [15:0] FLAG_LAST = 16'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_PROGRESS = 2'd1,
      KIND_COMPLETE = 2'd2
   } kind_type;

   typedef struct packed {
      logic        has_data;
      logic        has_prog;
      logic        prog_last;
      logic [7:0]  data_byte;
      logic [31:0] file_type;
      logic [31:0] frame_sequence;
      logic [31:0] received_count;
      logic [31:0] total_size;
   } job_type;

endpackage

### rtl/fixed_frame_payload_deframer_core.sv
`timescale 1ns / 1ps
// Fixed frame payload deframer: takes one stream byte per cycle unless
// req_stall is high, cuts the stream into 1024-byte frames with a 100-byte
// header and delivers payload bytes within the valid length plus a progress
// or complete result at each frame end. A payload result passes through the
// job queue and the output register. The last byte of a frame can yield two
// results, which the back end delivers one after the other from a four-job
// queue; req_stall is high only while that queue is full, which sustained
// output stalls cause. Depends on ffpd_pkg, ffpd_front, ffpd_queue and
// ffpd_back.
module fixed_frame_payload_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [31:0] rsp_file_type,
   output logic [31:0] rsp_frame_sequence,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_total_size,
   output logic        rsp_final_res
);
   import ffpd_pkg::*;

   logic    take;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    head_valid;
   job_type push_job;
   job_type head_job;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   ffpd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .push    (push),
      .job     (push_job)
   );

   ffpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (q_full)
   );

   ffpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_job           (head_job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_file_type      (rsp_file_type),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_received_count (rsp_received_count),
      .rsp_total_size     (rsp_total_size),
      .rsp_final_res      (rsp_final_res)
   );

endmodule

### rtl/ffpd_front.sv
`timescale 1ns / 1ps
// Front end: frame offset counter, header field capture, payload window
// check and saturating byte count. Emits one job per byte with results.
// Depends on ffpd_pkg.
module ffpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       in_byte,
   output logic             push,
   output ffpd_pkg::job_type job
);
   import ffpd_pkg::*;

   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [15:0]      flag_ff, flag_in;
   logic [31:0]      type_ff, type_in;
   logic [31:0]      seq_ff, seq_in;
   logic [31:0]      valid_len_ff, valid_len_in;
   logic [31:0]      total_ff, total_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      ofs32;
   logic [31:0]      count_step;
   logic             in_payload;
   logic             last_byte;
   logic             file_done;

   always_comb begin
      ofs32        = 32'(offset_ff);
      flag_in      = flag_ff;
      type_in      = type_ff;
      seq_in       = seq_ff;
      valid_len_in = valid_len_ff;
      total_in     = total_ff;

      if (ofs32 < 32'(OFS_TYPE)) begin
         flag_in = {flag_ff[7:0], in_byte};
      end else if (ofs32 < 32'(OFS_SEQ)) begin
         type_in = {type_ff[23:0], in_byte};
      end else if (ofs32 < 32'(OFS_VALID)) begin
         seq_in = {seq_ff[23:0], in_byte};
      end else if (ofs32 < 32'(OFS_TOTAL)) begin
         valid_len_in = {valid_len_ff[23:0], in_byte};
      end else if (ofs32 < 32'(OFS_HEADER_END)) begin
         total_in = {total_ff[23:0], in_byte};
      end

      in_payload = (ofs32 >= 32'(HEADER_BYTES)) &&
                   ((ofs32 - 32'(HEADER_BYTES)) < valid_len_ff);
      count_step = (in_payload && (count_ff != '1)) ? count_ff + 32'd1 : count_ff;
      last_byte  = (offset_ff == OFS_W'(FRAME_BYTES - 1));
      file_done  = last_byte && (flag_in == FLAG_LAST);
      offset_in  = last_byte ? '0 : offset_ff + OFS_W'(1);
      count_in   = file_done ? '0 : count_step;

      push               = take && (in_payload || last_byte);
      job.has_data       = in_payload;
      job.has_prog       = last_byte;
      job.prog_last      = file_done;
      job.data_byte      = in_byte;
      job.file_type      = type_in;
      job.frame_sequence = seq_in;
      job.received_count = count_step;
      job.total_size     = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         flag_ff      <= '0;
         type_ff      <= '0;
         seq_ff       <= '0;
         valid_len_ff <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
      end else if (take) begin
         offset_ff    <= offset_in;
         flag_ff      <= flag_in;
         type_ff      <= type_in;
         seq_ff       <= seq_in;
         valid_len_ff <= valid_len_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
      end
   end

endmodule

### rtl/ffpd_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back of the deframer.
// Depends on ffpd_pkg for the job record and depth.
module ffpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ffpd_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output ffpd_pkg::job_type head_job,
   output logic              full
);
   import ffpd_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      head_valid = (count_ff != '0);
      head_job   = mem_ff[rd_ptr_ff];
      full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in   = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/ffpd_back.sv
`timescale 1ns / 1ps
// Back end: expands each job into one or two results and holds them in
// the output register. Depends on ffpd_pkg.
module ffpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ffpd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_data_byte,
   output logic [31:0]       rsp_file_type,
   output logic [31:0]       rsp_frame_sequence,
   output logic [31:0]       rsp_received_count,
   output logic [31:0]       rsp_total_size,
   output logic              rsp_final_res
);
   import ffpd_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [31:0] type_ff, seq_ff, count_ff, total_ff;
   logic        final_ff, final_in;
   logic        out_free;
   logic        load;
   logic        split;
   logic        emit_data;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      load         = out_free && head_valid;
      split        = head_job.has_data && head_job.has_prog && !phase_ff;
      emit_data    = head_job.has_data && !phase_ff;
      pop          = load && !split;
      phase_in     = load ? split : phase_ff;
      rsp_valid_in = load ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
      if (emit_data) begin
         kind_in = KIND_DATA;
      end else if (head_job.prog_last) begin
         kind_in = KIND_COMPLETE;
      end else begin
         kind_in = KIND_PROGRESS;
      end
      data_in  = emit_data ? head_job.data_byte : 8'd0;
      final_in = !split;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         data_ff  <= data_in;
         type_ff  <= head_job.file_type;
         seq_ff   <= head_job.frame_sequence;
         count_ff <= head_job.received_count;
         total_ff <= head_job.total_size;
         final_ff <= final_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_file_type      = type_ff;
   assign rsp_frame_sequence = seq_ff;
   assign rsp_received_count = count_ff;
   assign rsp_total_size     = total_ff;
   assign rsp_final_res      = final_ff;

   a_phase_holds_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> rsp_valid_ff && (kind_ff == KIND_DATA) && !final_ff)
      else $error("second half pending without a held data result");

   a_phase_has_job: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_valid && head_job.has_data && head_job.has_prog)
      else $error("second half pending without a two-result job at the head");

   a_progress_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff != KIND_DATA) |-> (data_ff == 8'd0) && final_ff)
      else $error("progress result with data or not final");

endmodule

### tb/sv/ffpd_checker.sv
`timescale 1ns / 1ps
// Checker for the fixed frame payload deframer: watches both channels, predicts
// every result from the accepted stream bytes and compares field by field.
// Depends on ffpd_pkg for frame geometry, header offsets and result kinds.
module ffpd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [31:0] rsp_file_type,
   input  logic [31:0] rsp_frame_sequence,
   input  logic [31:0] rsp_received_count,
   input  logic [31:0] rsp_total_size,
   input  logic        rsp_final_res,
   output int          fail_count,
   output int          outstanding,
   output int          bytes_in,
   output int          payload_seen,
   output int          progress_seen,
   output int          complete_seen
);
   import ffpd_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [31:0] file_type;
      logic [31:0] frame_sequence;
      logic [31:0] received_count;
      logic [31:0] total_size;
      logic        final_res;
   } result_type;

   result_type expected_results[$];
   result_type want;

   int unsigned frame_pos;
   logic [15:0] flag_word;
   logic [31:0] type_word;
   logic [31:0] seq_word;
   logic [31:0] valid_len;
   logic [31:0] total_word;
   logic [31:0] byte_count;

   int mismatches = 0;
   int accepted = 0;
   int n_payload = 0;
   int n_progress = 0;
   int n_complete = 0;

   assign fail_count    = mismatches;
   assign bytes_in      = accepted;
   assign payload_seen  = n_payload;
   assign progress_seen = n_progress;
   assign complete_seen = n_complete;

   task automatic deframe_byte(input logic [7:0] b);
      int unsigned pos;
      result_type payload_res;
      result_type frame_res;
      bit has_payload;
      pos = frame_pos;
      has_payload = 1'b0;
      if (pos < OFS_TYPE) begin
         flag_word = {flag_word[7:0], b};
      end else if (pos < OFS_SEQ) begin
         type_word = {type_word[23:0], b};
      end else if (pos < OFS_VALID) begin
         seq_word = {seq_word[23:0], b};
      end else if (pos < OFS_TOTAL) begin
         valid_len = {valid_len[23:0], b};
      end else if (pos < OFS_HEADER_END) begin
         total_word = {total_word[23:0], b};
      end
      if (pos >= HEADER_BYTES && (pos - HEADER_BYTES) < valid_len) begin
         if (byte_count != 32'hFFFF_FFFF) byte_count = byte_count + 1;
         payload_res = '{KIND_DATA, b, type_word, seq_word, byte_count, total_word, 1'b0};
         has_payload = 1'b1;
      end
      if (pos + 1 >= FRAME_BYTES) begin
         frame_res = '{(flag_word == FLAG_LAST) ? KIND_COMPLETE : KIND_PROGRESS, 8'd0,
                       type_word, seq_word, byte_count, total_word, 1'b1};
         if (has_payload) expected_results.push_back(payload_res);
         expected_results.push_back(frame_res);
         if (flag_word == FLAG_LAST) byte_count = '0;
         frame_pos = 0;
      end else begin
         if (has_payload) begin
            payload_res.final_res = 1'b1;
            expected_results.push_back(payload_res);
         end
         frame_pos = pos + 1;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         frame_pos  = 0;
         flag_word  = '0;
         type_word  = '0;
         seq_word   = '0;
         valid_len  = '0;
         total_word = '0;
         byte_count = '0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted++;
            deframe_byte(req_in_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("rsp transaction with nothing expected: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               check_field("file_type", want.file_type, rsp_file_type);
               check_field("frame_sequence", want.frame_sequence, rsp_frame_sequence);
               check_field("received_count", want.received_count, rsp_received_count);
               check_field("total_size", want.total_size, rsp_total_size);
               check_field("final_res", 32'(want.final_res), 32'(rsp_final_res));
               case (want.kind)
                  KIND_DATA:     n_payload++;
                  KIND_PROGRESS: n_progress++;
                  default:       n_complete++;
               endcase
            end
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

### tb/sv/tb_fixed_frame_payload_deframer_core.sv
`timescale 1ns / 1ps
// Testbench top for fixed_frame_payload_deframer_core: drives a framed byte
// stream under varying idle and stall patterns and reports the verdict.
// Depends on ffpd_pkg, the block itself and ffpd_checker.
module tb_fixed_frame_payload_deframer_core;
   import ffpd_pkg::*;

   localparam int PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES;
   localparam int SPAN_BYTES    = FRAME_BYTES / 4;
   localparam int LONG_HOLD     = 200;
   localparam int TAIL_CYCLES   = 16;
   localparam int CYCLE_LIMIT   = 1000000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [31:0] rsp_file_type;
   logic [31:0] rsp_frame_sequence;
   logic [31:0] rsp_received_count;
   logic [31:0] rsp_total_size;
   logic        rsp_final_res;

   int fail_count;
   int outstanding;
   int bytes_in;
   int payload_seen;
   int progress_seen;
   int complete_seen;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   fixed_frame_payload_deframer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_file_type      (rsp_file_type),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_received_count (rsp_received_count),
      .rsp_total_size     (rsp_total_size),
      .rsp_final_res      (rsp_final_res)
   );

   ffpd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_file_type      (rsp_file_type),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_received_count (rsp_received_count),
      .rsp_total_size     (rsp_total_size),
      .rsp_final_res      (rsp_final_res),
      .fail_count         (fail_count),
      .outstanding        (outstanding),
      .bytes_in           (bytes_in),
      .payload_seen       (payload_seen),
      .progress_seen      (progress_seen),
      .complete_seen      (complete_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fixed_frame_payload_deframer_core: mismatch");
         $finish;
      end
   end

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // header is {flag, type, sequence, valid length, total size}
   task automatic send_span(input logic [143:0] hdr, input int unsigned first,
                            input int unsigned nbytes);
      int unsigned p;
      logic [7:0] b;
      for (p = first; p < first + nbytes; p++) begin
         if (p < OFS_HEADER_END) b = hdr[143 - 8 * p -: 8];
         else b = 8'($urandom);
         send_byte(b);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int phase;
      int sender_idle[4];
      int stall_mix[4];
      logic [143:0] hdr;
      sender_idle = '{0, 63, 0, 37};
      stall_mix   = '{0, 0, 63, 37};
      // last-frame flag, valid length one beyond the payload area
      hdr = {FLAG_LAST, 32'd3, 32'($urandom), 32'(PAYLOAD_BYTES + 1), 32'($urandom)};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = sender_idle[phase];
         stall_pct <= stall_mix[phase];
         if (phase == 0) hold_req <= hold_req + 1;
         send_span(hdr, 32'(phase * SPAN_BYTES), 32'(SPAN_BYTES));
         wait_drained();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d stream bytes: %0d payload bytes, %0d frame ends, %0d files",
               bytes_in, payload_seen, progress_seen + complete_seen, complete_seen);
      $display("one full frame in four spans: no idling, sender 63%%, receiver 63%%, both 37%%");
      if (fail_count == 0) begin
         $display("fixed_frame_payload_deframer_core: match");
      end else begin
         $display("fixed_frame_payload_deframer_core: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ffpd_pkg.sv
rtl/ffpd_front.sv
rtl/ffpd_queue.sv
rtl/ffpd_back.sv
rtl/fixed_frame_payload_deframer_core.sv
tb/sv/ffpd_checker.sv
tb/sv/tb_fixed_frame_payload_deframer_core.sv
